FILE: sv/lcdtr_pkg.sv
// Package for the LCD text renderer: microcode types, step addresses,
// operation codes and the fixed constants of the page-mode display.
// No dependencies; every other file of the block imports it.
`default_nettype none

package lcdtr_pkg;

  // Fixed widths of the request and result fields.
  localparam int MODE_W   = 3;
  localparam int SYM_W    = 8;
  localparam int FIDX_W   = 12;
  localparam int BYTE_W   = 8;
  localparam int RIDX_W   = 10;
  localparam int CURSOR_W = 8;

  // Display constants.
  localparam int PAGES      = 4;
  localparam int FIRST_CODE = 32;
  localparam int REF_CMDS   = 3;
  localparam logic [BYTE_W-1:0] CMD_COL_LO = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_COL_HI = 8'h10;
  localparam logic [BYTE_W-1:0] CMD_PAGE   = 8'hB0;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 3'd0,
    MODE_DRAW    = 3'd1,
    MODE_CLEAR   = 3'd2,
    MODE_CURSOR  = 3'd3,
    MODE_REFRESH = 3'd4
  } mode_t;

  // Datapath operations, one per control word.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLR_ALL_INIT,
    OP_CLR_LINE_INIT,
    OP_CLR_STEP,
    OP_FONT_WR,
    OP_CURS_CLR,
    OP_DRAW_INIT,
    OP_FONT_RD,
    OP_WID_CAP,
    OP_DRAW_UPPER,
    OP_DRAW_LOWER,
    OP_CURS_ADV,
    OP_REF_INIT,
    OP_REF_SUB,
    OP_REF_POS,
    OP_REF_DATA
  } dp_op_t;

  // How the step counter moves.
  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_JUMP_IF,
    C_DISPATCH,
    C_EMIT
  } cond_t;

  // Which datapath flag a conditional jump tests.
  typedef enum logic [2:0] {
    FL_NONE,
    FL_CNT_NZ,
    FL_BAD_SYM,
    FL_DRAW_END,
    FL_RIDX_BAD,
    FL_REM_GE,
    FL_POS_CMD
  } flag_t;

  typedef logic [4:0] upc_t;

  // Microprogram step addresses.
  localparam upc_t U_RST_INIT  = 5'd0;
  localparam upc_t U_RST_LOOP  = 5'd1;
  localparam upc_t U_IDLE      = 5'd2;
  localparam upc_t U_LOAD      = 5'd3;
  localparam upc_t U_CURS      = 5'd4;
  localparam upc_t U_CLR_INIT  = 5'd5;
  localparam upc_t U_CLR_LOOP  = 5'd6;
  localparam upc_t U_DONE      = 5'd7;
  localparam upc_t U_DRAW      = 5'd8;
  localparam upc_t U_DRAW_RDW  = 5'd9;
  localparam upc_t U_DRAW_WID  = 5'd10;
  localparam upc_t U_DRAW_U    = 5'd11;
  localparam upc_t U_DRAW_L    = 5'd12;
  localparam upc_t U_DRAW_ADV  = 5'd13;
  localparam upc_t U_REF       = 5'd14;
  localparam upc_t U_REF_DIV   = 5'd15;
  localparam upc_t U_REF_POS   = 5'd16;
  localparam upc_t U_REF_DATA  = 5'd17;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    flag_t  flag;
    upc_t   target;
  } ctrl_t;

  // Sequencer to datapath.
  typedef struct packed {
    dp_op_t op;
    logic   accept;
  } seq_ctl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic cnt_nz;
    logic bad_sym;
    logic draw_end;
    logic ridx_bad;
    logic rem_ge;
    logic pos_cmd;
  } flags_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              line_select;
    logic [SYM_W-1:0]  symbol;
    logic [FIDX_W-1:0] font_index;
    logic [BYTE_W-1:0] font_value;
    logic [RIDX_W-1:0] refresh_index;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                is_data;
    logic                status;
    logic [CURSOR_W-1:0] cursor_column;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/lcdtr_ifs.sv
// Valid/ready channel interfaces for the LCD text renderer: the request
// channel and the result channel. Depends on lcdtr_pkg for field widths.
`default_nettype none

interface lcdtr_in_if;
  import lcdtr_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic              line_select;
  logic [SYM_W-1:0]  symbol;
  logic [FIDX_W-1:0] font_index;
  logic [BYTE_W-1:0] font_value;
  logic [RIDX_W-1:0] refresh_index;

  modport source (output valid, mode, line_select, symbol, font_index, font_value,
                  refresh_index, input ready);
  modport sink (input valid, mode, line_select, symbol, font_index, font_value,
                refresh_index, output ready);
endinterface

interface lcdtr_out_if;
  import lcdtr_pkg::*;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic                is_data;
  logic                status;
  logic [CURSOR_W-1:0] cursor_column;

  modport source (output valid, out_byte, is_data, status, cursor_column, input ready);
  modport sink (input valid, out_byte, is_data, status, cursor_column, output ready);
endinterface

`default_nettype wire

FILE: sv/lcdtr_ucode_rom.sv
// Microcode ROM of the LCD text renderer: one control word per step.
// Depends on lcdtr_pkg.
`default_nettype none

module lcdtr_ucode_rom (
  input  lcdtr_pkg::upc_t  upc,
  output lcdtr_pkg::ctrl_t ctrl
);
  import lcdtr_pkg::*;

  always_comb begin
    case (upc)
      U_RST_INIT: ctrl = '{op: OP_CLR_ALL_INIT, cond: C_NEXT, flag: FL_NONE, target: U_IDLE};
      U_RST_LOOP: ctrl = '{op: OP_CLR_STEP, cond: C_JUMP_IF, flag: FL_CNT_NZ,
                           target: U_RST_LOOP};
      U_IDLE:     ctrl = '{op: OP_NOP, cond: C_DISPATCH, flag: FL_NONE, target: U_IDLE};
      U_LOAD:     ctrl = '{op: OP_FONT_WR, cond: C_JUMP, flag: FL_NONE, target: U_DONE};
      U_CURS:     ctrl = '{op: OP_CURS_CLR, cond: C_JUMP, flag: FL_NONE, target: U_DONE};
      U_CLR_INIT: ctrl = '{op: OP_CLR_LINE_INIT, cond: C_NEXT, flag: FL_NONE, target: U_DONE};
      U_CLR_LOOP: ctrl = '{op: OP_CLR_STEP, cond: C_JUMP_IF, flag: FL_CNT_NZ,
                           target: U_CLR_LOOP};
      U_DONE:     ctrl = '{op: OP_NOP, cond: C_EMIT, flag: FL_NONE, target: U_IDLE};
      U_DRAW:     ctrl = '{op: OP_DRAW_INIT, cond: C_JUMP_IF, flag: FL_BAD_SYM,
                           target: U_DONE};
      U_DRAW_RDW: ctrl = '{op: OP_FONT_RD, cond: C_NEXT, flag: FL_NONE, target: U_DONE};
      U_DRAW_WID: ctrl = '{op: OP_WID_CAP, cond: C_NEXT, flag: FL_NONE, target: U_DONE};
      U_DRAW_U:   ctrl = '{op: OP_DRAW_UPPER, cond: C_JUMP_IF, flag: FL_DRAW_END,
                           target: U_DRAW_ADV};
      U_DRAW_L:   ctrl = '{op: OP_DRAW_LOWER, cond: C_JUMP, flag: FL_NONE, target: U_DRAW_U};
      U_DRAW_ADV: ctrl = '{op: OP_CURS_ADV, cond: C_JUMP, flag: FL_NONE, target: U_DONE};
      U_REF:      ctrl = '{op: OP_REF_INIT, cond: C_JUMP_IF, flag: FL_RIDX_BAD,
                           target: U_DONE};
      U_REF_DIV:  ctrl = '{op: OP_REF_SUB, cond: C_JUMP_IF, flag: FL_REM_GE,
                           target: U_REF_DIV};
      U_REF_POS:  ctrl = '{op: OP_REF_POS, cond: C_JUMP_IF, flag: FL_POS_CMD,
                           target: U_DONE};
      U_REF_DATA: ctrl = '{op: OP_REF_DATA, cond: C_JUMP, flag: FL_NONE, target: U_DONE};
      default:    ctrl = '{op: OP_NOP, cond: C_JUMP, flag: FL_NONE, target: U_IDLE};
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/lcdtr_seq.sv
// Step counter of the LCD text renderer: fetches control words from the
// microcode ROM and resolves jumps and dispatch. Depends on lcdtr_pkg and
// lcdtr_ucode_rom.
`default_nettype none

module lcdtr_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcdtr_pkg::flags_t           flags,
  input  logic                        in_valid,
  input  logic [lcdtr_pkg::MODE_W-1:0] in_mode,
  input  logic                        slot_free,
  output logic                        in_ready,
  output logic                        emit,
  output lcdtr_pkg::seq_ctl_t         dp_ctl
);
  import lcdtr_pkg::*;

  upc_t  upc_r;
  upc_t  upc_nxt;
  upc_t  entry;
  ctrl_t ctrl;
  logic  flag_hit;

  lcdtr_ucode_rom u_rom (
    .upc  (upc_r),
    .ctrl (ctrl)
  );

  // Entry step of each request kind; unused modes go straight to the result.
  always_comb begin
    case (in_mode)
      MODE_LOAD:    entry = U_LOAD;
      MODE_DRAW:    entry = U_DRAW;
      MODE_CLEAR:   entry = U_CLR_INIT;
      MODE_CURSOR:  entry = U_CURS;
      MODE_REFRESH: entry = U_REF;
      default:      entry = U_DONE;
    endcase
  end

  always_comb begin
    case (ctrl.flag)
      FL_CNT_NZ:   flag_hit = flags.cnt_nz;
      FL_BAD_SYM:  flag_hit = flags.bad_sym;
      FL_DRAW_END: flag_hit = flags.draw_end;
      FL_RIDX_BAD: flag_hit = flags.ridx_bad;
      FL_REM_GE:   flag_hit = flags.rem_ge;
      FL_POS_CMD:  flag_hit = flags.pos_cmd;
      default:     flag_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (ctrl.cond)
      C_NEXT:     upc_nxt = upc_r + upc_t'(1);
      C_JUMP:     upc_nxt = ctrl.target;
      C_JUMP_IF:  upc_nxt = flag_hit ? ctrl.target : upc_r + upc_t'(1);
      C_DISPATCH: upc_nxt = in_valid ? entry : upc_r;
      C_EMIT:     upc_nxt = slot_free ? U_IDLE : upc_r;
      default:    upc_nxt = U_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (ctrl.cond == C_DISPATCH);
    emit          = (ctrl.cond == C_EMIT) && slot_free;
    dp_ctl.op     = ctrl.op;
    dp_ctl.accept = in_ready && in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_RST_INIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lcdtr_datapath.sv
// Datapath of the LCD text renderer: frame store, font store, cursors,
// counters and the result registers, driven by one operation per cycle.
// Depends on lcdtr_pkg.
`default_nettype none

module lcdtr_datapath #(
  parameter int COLUMNS       = 128,
  parameter int GLYPH_COUNT   = 96,
  parameter int GLYPH_BYTES   = 25,
  parameter int GLYPH_COLUMNS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lcdtr_pkg::seq_ctl_t ctl,
  input  lcdtr_pkg::req_t     req,
  output lcdtr_pkg::flags_t   flags,
  output lcdtr_pkg::res_t     res
);
  import lcdtr_pkg::*;

  localparam int FRAME_DEPTH = PAGES * COLUMNS;
  localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_BYTES;
  localparam int PAGE_WORDS  = REF_CMDS + COLUMNS;
  localparam int FA_W        = $clog2(FRAME_DEPTH);
  localparam int FONT_AW     = $clog2(FONT_DEPTH);
  localparam int FONT_CW     = $clog2(FONT_DEPTH + 1);
  localparam int FCMP_W      = (FONT_CW > FIDX_W) ? FONT_CW : FIDX_W;
  localparam int CUR_W       = $clog2(COLUMNS + 1);
  localparam int GCNT_W      = $clog2(GLYPH_COLUMNS + 1);
  localparam int CNT_W       = (FA_W > GCNT_W) ? FA_W : GCNT_W;
  localparam int K_TOP       = ((2 * GLYPH_COLUMNS + 2) > GLYPH_BYTES) ?
                               (2 * GLYPH_COLUMNS + 2) : GLYPH_BYTES;
  localparam int K_W         = $clog2(K_TOP + 1);
  localparam int SUM_W       = ((CUR_W > BYTE_W) ? CUR_W : BYTE_W) + 1;
  localparam int RC_W0       = $clog2(PAGES * PAGE_WORDS + 1);
  localparam int RC_W        = (RC_W0 > RIDX_W) ? RC_W0 : RIDX_W;
  localparam logic [FA_W-1:0] COLS_A = FA_W'(COLUMNS);

  logic [BYTE_W-1:0] frame_mem [FRAME_DEPTH];
  logic [BYTE_W-1:0] font_mem  [FONT_DEPTH];

  // Captured request.
  logic              line_r;
  logic [SYM_W-1:0]  sym_r;
  logic [FIDX_W-1:0] fidx_r;
  logic [BYTE_W-1:0] fval_r;
  logic [RIDX_W-1:0] ridx_r;

  // Working registers.
  logic [FONT_AW-1:0] base_r;
  logic [K_W-1:0]     k_r;
  logic [CUR_W-1:0]   col_r;
  logic [CUR_W-1:0]   colp_r;
  logic               pend_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [FA_W-1:0]    fa_r;
  logic [BYTE_W-1:0]  width_r;
  logic [RIDX_W-1:0]  rem_r;
  logic [1:0]         page_r;
  logic [CUR_W-1:0]   cur_r [2];

  // Result registers.
  logic [BYTE_W-1:0] byte_r;
  logic              data_r;
  logic              status_r;

  // Memory read data.
  logic [BYTE_W-1:0] font_q_r;
  logic              fz_r;
  logic [BYTE_W-1:0] frame_q_r;

  logic               fr_we;
  logic [FA_W-1:0]    fr_wa;
  logic [BYTE_W-1:0]  fr_wd;
  logic               fr_re;
  logic [FA_W-1:0]    fr_ra;
  logic               fn_we;
  logic               fn_re;
  logic [FONT_AW-1:0] fn_ra;
  logic               k_past;
  logic [BYTE_W-1:0]  fdat;
  logic [SYM_W-1:0]   glyph;
  logic [CUR_W-1:0]   cur_sel;
  logic [SUM_W-1:0]   adv_sum;
  logic [CUR_W-1:0]   adv_cur;
  logic [FA_W-1:0]    row0_base;
  logic [FA_W-1:0]    row1_base;
  logic [FA_W-1:0]    page_base;

  assign fdat      = fz_r ? '0 : font_q_r;
  assign k_past    = (k_r >= K_W'(GLYPH_BYTES));
  assign glyph     = sym_r - SYM_W'(FIRST_CODE);
  assign cur_sel   = cur_r[line_r];
  assign adv_sum   = SUM_W'(cur_sel) + SUM_W'(width_r);
  assign adv_cur   = (adv_sum > SUM_W'(COLUMNS)) ? CUR_W'(COLUMNS) : CUR_W'(adv_sum);
  assign row0_base = FA_W'({line_r, 1'b0}) * COLS_A;
  assign row1_base = FA_W'({line_r, 1'b1}) * COLS_A;
  assign page_base = FA_W'(page_r) * COLS_A;

  always_comb begin
    flags.cnt_nz   = (cnt_r != '0);
    flags.bad_sym  = (sym_r < SYM_W'(FIRST_CODE)) ||
                     ({1'b0, sym_r} >= (SYM_W + 1)'(FIRST_CODE + GLYPH_COUNT));
    flags.draw_end = (col_r == CUR_W'(COLUMNS)) || (cnt_r == CNT_W'(GLYPH_COLUMNS));
    flags.ridx_bad = (RC_W'(ridx_r) >= RC_W'(PAGES * PAGE_WORDS));
    flags.rem_ge   = (RC_W'(rem_r) >= RC_W'(PAGE_WORDS));
    flags.pos_cmd  = (rem_r < RIDX_W'(REF_CMDS));
  end

  always_comb begin
    res.out_byte      = byte_r;
    res.is_data       = data_r;
    res.status        = status_r;
    res.cursor_column = CURSOR_W'(cur_sel);
  end

  // Memory port controls for the current operation.
  always_comb begin
    fr_we = 1'b0;
    fr_wa = fa_r;
    fr_wd = '0;
    fr_re = 1'b0;
    fr_ra = page_base + FA_W'(rem_r - RIDX_W'(REF_CMDS));
    fn_we = 1'b0;
    fn_re = 1'b0;
    fn_ra = base_r + FONT_AW'(k_r);
    case (ctl.op)
      OP_CLR_STEP: begin
        fr_we = 1'b1;
      end
      OP_FONT_WR: begin
        fn_we = (FCMP_W'(fidx_r) < FCMP_W'(FONT_DEPTH));
      end
      OP_FONT_RD: begin
        fn_re = !k_past;
      end
      OP_DRAW_UPPER: begin
        fr_we = pend_r;
        fr_wa = row1_base + FA_W'(colp_r);
        fr_wd = fdat;
        fn_re = !flags.draw_end && !k_past;
      end
      OP_DRAW_LOWER: begin
        fr_we = 1'b1;
        fr_wa = row0_base + FA_W'(col_r);
        fr_wd = fdat;
        fn_re = !k_past;
      end
      OP_REF_POS: begin
        fr_re = !flags.pos_cmd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fr_we) begin
      frame_mem[fr_wa] <= fr_wd;
    end
    if (fr_re) begin
      frame_q_r <= frame_mem[fr_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (fn_we) begin
      font_mem[FONT_AW'(fidx_r)] <= fval_r;
    end
    if (fn_re) begin
      font_q_r <= font_mem[fn_ra];
    end
  end

  // Cursors and the pending lower-page write are cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r[0] <= '0;
      cur_r[1] <= '0;
      pend_r   <= 1'b0;
    end else begin
      case (ctl.op)
        OP_CURS_CLR: begin
          cur_r[0] <= '0;
          cur_r[1] <= '0;
        end
        OP_CURS_ADV: begin
          cur_r[line_r] <= adv_cur;
        end
        OP_DRAW_INIT:  pend_r <= 1'b0;
        OP_DRAW_UPPER: pend_r <= 1'b0;
        OP_DRAW_LOWER: pend_r <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      line_r   <= req.line_select;
      sym_r    <= req.symbol;
      fidx_r   <= req.font_index;
      fval_r   <= req.font_value;
      ridx_r   <= req.refresh_index;
      byte_r   <= '0;
      data_r   <= 1'b0;
      status_r <= 1'b0;
    end
    case (ctl.op)
      OP_CLR_ALL_INIT: begin
        fa_r  <= '0;
        cnt_r <= CNT_W'(FRAME_DEPTH - 1);
      end
      OP_CLR_LINE_INIT: begin
        fa_r  <= row0_base;
        cnt_r <= CNT_W'(2 * COLUMNS - 1);
      end
      OP_CLR_STEP: begin
        fa_r  <= fa_r + FA_W'(1);
        cnt_r <= cnt_r - CNT_W'(1);
      end
      OP_DRAW_INIT: begin
        status_r <= flags.bad_sym;
        base_r   <= FONT_AW'(int'(glyph) * GLYPH_BYTES);
        k_r      <= '0;
        col_r    <= cur_sel;
        cnt_r    <= '0;
      end
      OP_FONT_RD: begin
        fz_r <= k_past;
        k_r  <= k_r + K_W'(1);
      end
      OP_WID_CAP: begin
        width_r <= fdat;
      end
      OP_DRAW_UPPER: begin
        if (!flags.draw_end) begin
          fz_r <= k_past;
          k_r  <= k_r + K_W'(1);
        end
      end
      OP_DRAW_LOWER: begin
        fz_r   <= k_past;
        k_r    <= k_r + K_W'(1);
        colp_r <= col_r;
        col_r  <= col_r + CUR_W'(1);
        cnt_r  <= cnt_r + CNT_W'(1);
      end
      OP_REF_INIT: begin
        rem_r  <= ridx_r;
        page_r <= '0;
      end
      OP_REF_SUB: begin
        if (flags.rem_ge) begin
          rem_r  <= rem_r - RIDX_W'(PAGE_WORDS);
          page_r <= page_r + 2'd1;
        end
      end
      OP_REF_POS: begin
        if (rem_r == RIDX_W'(0)) begin
          byte_r <= CMD_COL_LO;
        end else if (rem_r == RIDX_W'(1)) begin
          byte_r <= CMD_COL_HI;
        end else if (rem_r == RIDX_W'(2)) begin
          byte_r <= CMD_PAGE | BYTE_W'(page_r);
        end
      end
      OP_REF_DATA: begin
        byte_r <= frame_q_r;
        data_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/lcd_text_framebuffer_renderer.sv
// Top level of the LCD text renderer: request and result channels, the
// microcoded sequencer, the datapath and the result register.
// Depends on lcdtr_pkg, lcdtr_ifs, lcdtr_seq and lcdtr_datapath.
//
//   Channel   Direction  Handshake     Carries
//   in_chan   sink       valid/ready   mode, line_select, symbol, font_index,
//                                      font_value, refresh_index
//   out_chan  source     valid/ready   out_byte, is_data, status, cursor_column
//
// Requests are taken one at a time. A refresh word finds its page by up to
// three subtractions and then gives a command or a data byte read from the
// frame store; an index past the stream, like a code outside the font in a
// draw, goes straight to the result. A draw writes each glyph column that
// lands on the frame. The frame store takes one write a cycle and the font
// store gives one read a cycle.
// After reset the frame store is cleared by a sweep during which no request
// is accepted. A waiting result does not block acceptance; only a second
// result stalls, in the final step, until the first is taken.
`default_nettype none

module lcd_text_framebuffer_renderer #(
  parameter int COLUMNS       = 128,
  parameter int GLYPH_COUNT   = 96,
  parameter int GLYPH_BYTES   = 25,
  parameter int GLYPH_COLUMNS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  lcdtr_in_if.sink    in_chan,
  lcdtr_out_if.source out_chan
);
  import lcdtr_pkg::*;

  seq_ctl_t dp_ctl;
  flags_t   flags;
  req_t     req;
  res_t     res;
  logic     slot_free;
  logic     emit;
  logic     in_ready;

  // Result register; it is refilled in the same cycle that it is taken.
  logic out_valid_r;
  res_t out_res_r;

  assign slot_free = !out_valid_r || out_chan.ready;

  // Flatten the request channel into the datapath's request struct.
  always_comb begin
    req.mode          = in_chan.mode;
    req.line_select   = in_chan.line_select;
    req.symbol        = in_chan.symbol;
    req.font_index    = in_chan.font_index;
    req.font_value    = in_chan.font_value;
    req.refresh_index = in_chan.refresh_index;
  end

  assign in_chan.ready = in_ready;

  // The sequencer steps through the microprogram and dispatches each
  // accepted request to the entry step of its mode.
  lcdtr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .flags     (flags),
    .in_valid  (in_chan.valid),
    .in_mode   (in_chan.mode),
    .slot_free (slot_free),
    .in_ready  (in_ready),
    .emit      (emit),
    .dp_ctl    (dp_ctl)
  );

  // The datapath holds both stores and executes one operation per cycle.
  lcdtr_datapath #(
    .COLUMNS       (COLUMNS),
    .GLYPH_COUNT   (GLYPH_COUNT),
    .GLYPH_BYTES   (GLYPH_BYTES),
    .GLYPH_COLUMNS (GLYPH_COLUMNS)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dp_ctl),
    .req   (req),
    .flags (flags),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_byte      = out_res_r.out_byte;
  assign out_chan.is_data       = out_res_r.is_data;
  assign out_chan.status        = out_res_r.status;
  assign out_chan.cursor_column = out_res_r.cursor_column;

endmodule

`default_nettype wire

FILE: test/tb_lcd_text_framebuffer_renderer.sv
// Testbench for the LCD text renderer. A directed table comes first, then random font loads,
// glyph draws, line clears and refresh reads; a behavioral predictor checks untyped rows.
// Depends on lcdtr_pkg, lcdtr_ifs and the lcd_text_framebuffer_renderer RTL.

module tb_lcd_text_framebuffer_renderer;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdtr_pkg::*;

  // Geometry of the block as it is built here.
  localparam int COLS          = 128;
  localparam int GLYPHS        = 96;
  localparam int GLYPH_LEN     = 25;
  localparam int GLYPH_COLS    = 12;
  localparam int FONT_DEPTH    = GLYPHS * GLYPH_LEN;
  localparam int FRAME_BYTES   = PAGES * COLS;
  localparam int PAGE_WORDS    = REF_CMDS + COLS;
  localparam int REFRESH_WORDS = PAGES * PAGE_WORDS;

  // Codes that the package does not name.
  localparam logic [MODE_W-1:0] MODE_UNUSED_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;
  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_BAD_SYMBOL = 1'b1;

  // Run shape.
  localparam int ITEM_TARGET  = 1300;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 300;

  // One row of the directed table. Where typed is set, want is the response that is
  // checked; otherwise the predictor supplies it.
  typedef struct packed {
    req_t req;
    logic typed;
    res_t want;
  } table_row_t;

  localparam res_t QUIET = '{8'h00, 1'b0, STATUS_OK, 8'd0};
  localparam res_t BAD   = '{8'h00, 1'b0, STATUS_BAD_SYMBOL, 8'd0};

  // After reset the frame store is all zero and both cursors sit at column zero, so every
  // typed row below expects cursor zero. No row draws a glyph that exists, since the font
  // holds nothing yet.
  localparam int ROWS = 24;
  localparam table_row_t DIRECTED [ROWS] = '{
    // Refresh stream: the three commands of page zero and its first data byte.
    '{'{MODE_REFRESH, 1'b0, 8'h00, 12'h000, 8'h00, 10'd0}, 1'b1, '{CMD_COL_LO, 1'b0,
      STATUS_OK, 8'd0}},
    '{'{MODE_REFRESH, 1'b0, 8'h00, 12'h000, 8'h00, 10'd1}, 1'b1, '{CMD_COL_HI, 1'b0,
      STATUS_OK, 8'd0}},
    '{'{MODE_REFRESH, 1'b0, 8'h00, 12'h000, 8'h00, 10'd2}, 1'b1, '{CMD_PAGE, 1'b0,
      STATUS_OK, 8'd0}},
    '{'{MODE_REFRESH, 1'b0, 8'h00, 12'h000, 8'h00, 10'd3}, 1'b1, '{8'h00, 1'b1,
      STATUS_OK, 8'd0}},
    // Page command of the last page, and the very last word of the stream.
    '{'{MODE_REFRESH, 1'b1, 8'h00, 12'h000, 8'h00, 10'd395}, 1'b1, '{CMD_PAGE | 8'h03, 1'b0,
      STATUS_OK, 8'd0}},
    '{'{MODE_REFRESH, 1'b1, 8'h00, 12'h000, 8'h00, 10'd523}, 1'b1, '{8'h00, 1'b1,
      STATUS_OK, 8'd0}},
    // Refresh index past the stream, just past and at the field's top.
    '{'{MODE_REFRESH, 1'b0, 8'h00, 12'h000, 8'h00, 10'd524}, 1'b1, QUIET},
    '{'{MODE_REFRESH, 1'b1, 8'hFF, 12'hFFF, 8'hFF, 10'd1023}, 1'b1, QUIET},
    // Codes outside the font on both sides, on both lines.
    '{'{MODE_DRAW, 1'b0, 8'd0, 12'h000, 8'h00, 10'd0}, 1'b1, BAD},
    '{'{MODE_DRAW, 1'b1, 8'd31, 12'h000, 8'h00, 10'd0}, 1'b1, BAD},
    '{'{MODE_DRAW, 1'b0, 8'd128, 12'hFFF, 8'hFF, 10'd1023}, 1'b1, BAD},
    '{'{MODE_DRAW, 1'b1, 8'd255, 12'h000, 8'h00, 10'd0}, 1'b1, BAD},
    // Font addresses out of range are dropped; the ends of the range are stored.
    '{'{MODE_LOAD, 1'b0, 8'h00, 12'd2400, 8'hFF, 10'd0}, 1'b1, QUIET},
    '{'{MODE_LOAD, 1'b1, 8'hFF, 12'hFFF, 8'hAA, 10'd1023}, 1'b1, QUIET},
    '{'{MODE_LOAD, 1'b0, 8'h00, 12'd0, 8'h00, 10'd0}, 1'b1, QUIET},
    '{'{MODE_LOAD, 1'b1, 8'h00, 12'd2399, 8'hFF, 10'd0}, 1'b1, QUIET},
    // Unused modes do nothing and answer like a load.
    '{'{MODE_UNUSED_5, 1'b1, 8'hFF, 12'hFFF, 8'hFF, 10'd1023}, 1'b1, QUIET},
    '{'{MODE_UNUSED_6, 1'b0, 8'd40, 12'd7, 8'h5A, 10'd3}, 1'b1, QUIET},
    '{'{MODE_UNUSED_7, 1'b1, 8'hFF, 12'hFFF, 8'hFF, 10'd1023}, 1'b1, QUIET},
    // Line clears and a cursor reset.
    '{'{MODE_CLEAR, 1'b0, 8'h00, 12'h000, 8'h00, 10'd0}, 1'b1, QUIET},
    '{'{MODE_CLEAR, 1'b1, 8'h00, 12'h000, 8'h00, 10'd0}, 1'b1, QUIET},
    '{'{MODE_CURSOR, 1'b0, 8'h00, 12'h000, 8'h00, 10'd0}, 1'b1, QUIET},
    // Page boundaries inside the stream, left to the predictor.
    '{'{MODE_REFRESH, 1'b0, 8'h00, 12'h000, 8'h00, 10'd131}, 1'b0, QUIET},
    '{'{MODE_REFRESH, 1'b1, 8'h00, 12'h000, 8'h00, 10'd264}, 1'b0, QUIET}
  };

  logic clk;
  logic rst_n;

  lcdtr_in_if  in_if ();
  lcdtr_out_if out_if ();

  lcd_text_framebuffer_renderer #(
    .COLUMNS      (COLS),
    .GLYPH_COUNT  (GLYPHS),
    .GLYPH_BYTES  (GLYPH_LEN),
    .GLYPH_COLUMNS(GLYPH_COLS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  // Predictor state: the frame as the display would show it, the font as loaded so far,
  // which font bytes have been written, and the two text cursors.
  bit [7:0]    frame_mem    [FRAME_BYTES];
  bit [7:0]    font_mem     [FONT_DEPTH];
  bit          font_written [FONT_DEPTH];
  int unsigned cursor_one;
  int unsigned cursor_two;

  res_t        due_responses [$];
  int unsigned drawable_codes [$];
  int unsigned items_taken;
  int unsigned mismatches;

  // Idle rates in percent, changed by the stimulus process as the run moves on.
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  // Each increment asks the receiver for one long hold-off.
  int unsigned hold_requests;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("lcd_text_framebuffer_renderer test failed");
    $finish;
  end

  function automatic bit code_in_font(input logic [SYM_W-1:0] code);
    return code >= FIRST_CODE && code < FIRST_CODE + GLYPHS;
  endfunction

  // A glyph may be drawn only once every byte of its record has been written, since the
  // font store holds nothing defined before that.
  function automatic bit glyph_ready(input int unsigned code);
    int unsigned base;
    int unsigned k;
    if (!code_in_font(8'(code))) return 1'b0;
    base = (code - FIRST_CODE) * GLYPH_LEN;
    for (k = 0; k < GLYPH_LEN; k++) begin
      if (!font_written[base + k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Bytes past the glyph record read as zero.
  function automatic bit [7:0] glyph_byte(input int unsigned base, input int unsigned k);
    if (k >= GLYPH_LEN) return 8'h00;
    return font_mem[base + k];
  endfunction

  // Applies one request to the predictor state and returns the response it should give.
  function automatic res_t predict_lcd_step(input req_t r);
    res_t        o;
    int unsigned cur;
    int unsigned base;
    int unsigned nxt;
    int unsigned page;
    int unsigned pos;
    int unsigned row;
    int unsigned i;
    o = '0;
    // First byte of the selected line's upper page; its lower page follows one row later.
    row = r.line_select ? 2 * COLS : 0;
    case (r.mode)
      MODE_LOAD: begin
        if (r.font_index < FONT_DEPTH) begin
          font_mem[r.font_index] = r.font_value;
          font_written[r.font_index] = 1'b1;
        end
      end
      MODE_DRAW: begin
        if (!code_in_font(r.symbol)) begin
          o.status = STATUS_BAD_SYMBOL;
        end else begin
          cur = r.line_select ? cursor_two : cursor_one;
          base = (r.symbol - FIRST_CODE) * GLYPH_LEN;
          // Columns that fall past the right edge are lost, never wrapped.
          for (i = 0; i < GLYPH_COLS && cur + i < COLS; i++) begin
            frame_mem[row + cur + i] = glyph_byte(base, 1 + 2 * i);
            frame_mem[row + COLS + cur + i] = glyph_byte(base, 2 + 2 * i);
          end
          nxt = cur + glyph_byte(base, 0);
          if (nxt > COLS) nxt = COLS;
          if (r.line_select) cursor_two = nxt;
          else cursor_one = nxt;
        end
      end
      MODE_CLEAR: begin
        for (i = 0; i < 2 * COLS; i++) frame_mem[row + i] = 8'h00;
      end
      MODE_CURSOR: begin
        cursor_one = 0;
        cursor_two = 0;
      end
      MODE_REFRESH: begin
        if (r.refresh_index < REFRESH_WORDS) begin
          page = r.refresh_index / PAGE_WORDS;
          pos = r.refresh_index % PAGE_WORDS;
          // Each page opens with column low, column high and page address commands.
          if (pos == 0) begin
            o.out_byte = CMD_COL_LO;
          end else if (pos == 1) begin
            o.out_byte = CMD_COL_HI;
          end else if (pos == 2) begin
            o.out_byte = CMD_PAGE | 8'(page);
          end else begin
            o.out_byte = frame_mem[page * COLS + pos - REF_CMDS];
            o.is_data = 1'b1;
          end
        end
      end
      default: ;
    endcase
    o.cursor_column = 8'(r.line_select ? cursor_two : cursor_one);
    return o;
  endfunction

  function automatic req_t mk_req(input logic [MODE_W-1:0] mode, input logic line,
                                  input logic [SYM_W-1:0] code,
                                  input logic [FIDX_W-1:0] fidx,
                                  input logic [BYTE_W-1:0] fval,
                                  input logic [RIDX_W-1:0] ridx);
    req_t r;
    r.mode = mode;
    r.line_select = line;
    r.symbol = code;
    r.font_index = fidx;
    r.font_value = fval;
    r.refresh_index = ridx;
    return r;
  endfunction

  // Offers one request after a random idle gap and holds it until the block takes it.
  // The expected response is queued at the edge where the request is accepted.
  task automatic push_req(input req_t r, input bit typed, input res_t want);
    res_t model_res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= r.mode;
    in_if.line_select <= r.line_select;
    in_if.symbol <= r.symbol;
    in_if.font_index <= r.font_index;
    in_if.font_value <= r.font_value;
    in_if.refresh_index <= r.refresh_index;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    model_res = predict_lcd_step(r);
    due_responses.push_back(typed ? want : model_res);
    items_taken++;
  endtask

  // Writes a whole glyph record with random columns. The width byte leans toward
  // realistic values, with zero and very wide glyphs now and then so that the cursor
  // both stands still and saturates.
  task automatic load_glyph(input int unsigned code);
    int unsigned base;
    int unsigned k;
    int unsigned roll;
    logic [7:0]  value;
    base = (code - FIRST_CODE) * GLYPH_LEN;
    for (k = 0; k < GLYPH_LEN; k++) begin
      value = 8'($urandom);
      if (k == 0) begin
        roll = $urandom_range(9);
        if (roll == 0) value = 8'h00;
        else if (roll == 1) value = 8'($urandom);
        else value = 8'($urandom_range(6, 16));
      end
      push_req(mk_req(MODE_LOAD, 1'($urandom), 8'($urandom), 12'(base + k), value,
                      10'($urandom)), 1'b0, QUIET);
    end
  endtask

  // Receiver: checks each accepted response against the oldest expectation and drives
  // ready, with random stalls and, on request, one long hold-off so that the block backs
  // up and stops taking requests.
  task automatic check_response();
    res_t want;
    if (due_responses.size() == 0) begin
      $error("response with none expected: out_byte %0h is_data %0b status %0b cursor %0d",
             out_if.out_byte, out_if.is_data, out_if.status, out_if.cursor_column);
      mismatches++;
    end else begin
      want = due_responses.pop_front();
      if (out_if.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, actual %0h", want.out_byte, out_if.out_byte);
        mismatches++;
      end
      if (out_if.is_data !== want.is_data) begin
        $error("is_data: expected %0b, actual %0b", want.is_data, out_if.is_data);
        mismatches++;
      end
      if (out_if.status !== want.status) begin
        $error("status: expected %0b, actual %0b", want.status, out_if.status);
        mismatches++;
      end
      if (out_if.cursor_column !== want.cursor_column) begin
        $error("cursor_column: expected %0d, actual %0d", want.cursor_column,
               out_if.cursor_column);
        mismatches++;
      end
    end
  endtask

  initial begin
    int unsigned holds_served;
    int unsigned hold_left;
    holds_served = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) check_response();
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Stimulus: reset, the directed table, then random traffic in three idle phases.
  initial begin
    int unsigned i;
    int unsigned roll;
    int unsigned code;
    int unsigned n;
    int unsigned start;
    int unsigned len;
    int unsigned phase;
    logic        line;
    req_t        r;

    items_taken = 0;
    mismatches = 0;
    hold_requests = 0;
    cursor_one = 0;
    cursor_two = 0;
    src_idle_pct = 16;
    sink_idle_pct = 65;
    phase = 1;

    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.mode <= MODE_LOAD;
    in_if.line_select <= 1'b0;
    in_if.symbol <= '0;
    in_if.font_index <= '0;
    in_if.font_value <= '0;
    in_if.refresh_index <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // The block sweeps its frame store after reset; the first request simply waits
    // for ready.
    for (i = 0; i < ROWS; i++) begin
      push_req(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);
    end

    while (items_taken < ITEM_TARGET) begin
      // Second phase: the sender idles a lot and the receiver little. Third phase: no
      // idling at all. The second and third phases each open with a long receiver
      // hold-off while the sender keeps offering.
      if (phase == 1 && items_taken >= ITEM_TARGET / 3) begin
        phase = 2;
        src_idle_pct = 65;
        sink_idle_pct = 16;
        hold_requests++;
      end else if (phase == 2 && items_taken >= 2 * ITEM_TARGET / 3) begin
        phase = 3;
        src_idle_pct = 0;
        sink_idle_pct = 0;
        hold_requests++;
      end

      roll = $urandom_range(99);
      if (roll < 45) begin
        // A run of draws of one glyph on one line, loading the glyph first when its
        // record is incomplete and now and then rewriting it with new content.
        if (drawable_codes.size() != 0 && $urandom_range(99) < 70) begin
          code = drawable_codes[$urandom_range(drawable_codes.size() - 1)];
        end else begin
          code = $urandom_range(FIRST_CODE, FIRST_CODE + GLYPHS - 1);
        end
        if (!glyph_ready(code)) begin
          load_glyph(code);
          drawable_codes.push_back(code);
        end else if ($urandom_range(9) == 0) begin
          load_glyph(code);
        end
        line = 1'($urandom);
        n = $urandom_range(1, 6);
        repeat (n) begin
          push_req(mk_req(MODE_DRAW, line, 8'(code), 12'($urandom), 8'($urandom),
                          10'($urandom)), 1'b0, QUIET);
        end
      end else if (roll < 70) begin
        // A stretch of the refresh stream; it may run past the last word.
        start = $urandom_range(REFRESH_WORDS - 1);
        len = $urandom_range(1, 24);
        for (i = 0; i < len; i++) begin
          push_req(mk_req(MODE_REFRESH, 1'($urandom), 8'($urandom), 12'($urandom),
                          8'($urandom), 10'(start + i)), 1'b0, QUIET);
        end
      end else if (roll < 78) begin
        push_req(mk_req(MODE_CLEAR, 1'($urandom), 8'($urandom), 12'($urandom),
                        8'($urandom), 10'($urandom)), 1'b0, QUIET);
      end else if (roll < 84) begin
        push_req(mk_req(MODE_CURSOR, 1'($urandom), 8'($urandom), 12'($urandom),
                        8'($urandom), 10'($urandom)), 1'b0, QUIET);
      end else begin
        // Noise: any mode with any fields, except that a draw never names a glyph
        // whose record is not fully written.
        n = $urandom_range(1, 4);
        repeat (n) begin
          r = mk_req(3'($urandom), 1'($urandom), 8'($urandom), 12'($urandom),
                     8'($urandom), 10'($urandom));
          if (r.mode == MODE_DRAW && code_in_font(r.symbol) && !glyph_ready(r.symbol)) begin
            r.symbol = $urandom_range(1) ? 8'($urandom_range(31))
                                         : 8'($urandom_range(128, 255));
          end
          push_req(r, 1'b0, QUIET);
        end
      end
    end

    in_if.valid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk);
    // Any stray response would show up within the longest operation.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("lcd_text_framebuffer_renderer test passed");
    end else begin
      $display("lcd_text_framebuffer_renderer test failed");
    end
    $finish;
  end

endmodule
